// ===== design/jadm_pkg.sv =====
// package with constants, types and helpers for the joystick average deadband map
`default_nettype none
package jadm_pkg;

   localparam int CHANNELS     = 4;
   localparam int FRAME_EVENTS = 10;

   localparam int SAMPLE_W = 24;
   localparam int SUM_W    = 27;
   localparam int AXIS_W   = 8;
   localparam int CNT_W    = $clog2(FRAME_EVENTS);
   localparam int NEXT_W   = CNT_W + 1;
   localparam int ENABLE_W = 3;

   localparam int REQ_BITS   = CHANNELS * SAMPLE_W + ENABLE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = CHANNELS * AXIS_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int SCALE_MUL   = 100;
   localparam int SCALE_SHIFT = 24;
   localparam int PROD_W      = SUM_W + 7;
   localparam int VRAW_W      = PROD_W - SCALE_SHIFT;
   localparam int V_W         = 9;

   localparam logic [V_W-1:0] V_MIN       = V_W'(50);
   localparam logic [V_W-1:0] V_MAX       = V_W'(450);
   localparam logic [V_W-1:0] V_CENTER    = V_W'(250);
   localparam logic [V_W-1:0] V_DEAD_LOW  = V_W'(240);
   localparam logic [V_W-1:0] V_DEAD_HIGH = V_W'(260);

   localparam logic [AXIS_W-1:0] AXIS_CENTER = AXIS_W'(128);
   localparam logic [AXIS_W-1:0] AXIS_BASE   = AXIS_W'(127);

   // floor(x/25) for x below 3225 as (x*1311)>>15
   localparam int QX_W     = 12;
   localparam int RECIP_25 = 1311;
   localparam int RECIP_SH = 15;
   localparam int QPROD_W  = QX_W + 11;

   localparam int ENA_PAIR  = 0;
   localparam int ENA_LEFT  = 1;
   localparam int ENA_RIGHT = 2;

   typedef struct packed {
      logic accept;
      logic add;
      logic close;
      logic s2_load;
   } lane_ctrl_type;

   function automatic logic lane_enable(input int ch, input logic [ENABLE_W-1:0] ena);
      logic sel;
      if (ch < 2) begin
         sel = ena[ENA_PAIR];
      end else if (ch == 2) begin
         sel = ena[ENA_LEFT];
      end else begin
         sel = ena[ENA_RIGHT];
      end
      return sel;
   endfunction

endpackage
`default_nettype wire

// ===== design/joystick_average_deadband_map.sv =====
// top level: event counter, channel lanes and result register
// Takes one converter event per cycle. Even-numbered events of a frame add
// their samples into per-channel sums; the closing event of each frame
// (every FRAME_EVENTS events) sends the sums through a scale stage and a
// deadband map stage into the result register. Only closing events can
// stall on a full result path; other events are always taken.
`default_nettype none
module joystick_average_deadband_map
   import jadm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // sample_ch0..sample_ch(n-1), enable_pair, enable_left, enable_right
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // axis_0, axis_1, axis_2, axis_3
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [NEXT_W-1:0] next;
   logic              closing;
   logic              accept;
   logic              s1_v_ff, s1_v_in;
   logic              s2_v_ff, s2_v_in;
   logic              s1_ready, s2_ready, out_ready;
   logic              s2_load;
   logic [ENABLE_W-1:0] ena;
   lane_ctrl_type     ctrl;
   logic [CHANNELS-1:0][AXIS_W-1:0] axes;

   assign next     = NEXT_W'(count_ff) + NEXT_W'(1);
   assign closing  = next >= NEXT_W'(FRAME_EVENTS);
   assign s2_ready = !s2_v_ff || out_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign req_tready = !closing || s1_ready;
   assign accept   = req_tvalid && req_tready;
   assign s2_load  = s1_v_ff && s2_ready;
   assign ena      = req_tdata[CHANNELS*SAMPLE_W +: ENABLE_W];

   always_comb begin
      ctrl.accept  = accept;
      ctrl.add     = !next[0];
      ctrl.close   = closing;
      ctrl.s2_load = s2_load;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = closing ? '0 : next[CNT_W-1:0];
      end
      s1_v_in = s1_v_ff;
      if (accept && closing) begin
         s1_v_in = 1'b1;
      end else if (s2_ready) begin
         s1_v_in = 1'b0;
      end
      s2_v_in = s2_v_ff;
      if (s2_load) begin
         s2_v_in = 1'b1;
      end else if (out_ready) begin
         s2_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
      end
   end

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      jadm_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .sample (req_tdata[ch*SAMPLE_W +: SAMPLE_W]),
         .enable (lane_enable(ch, ena)),
         .ctrl   (ctrl),
         .axis   (axes[ch])
      );
   end

   jadm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s2_v_ff),
      .axes       (axes),
      .load_ready (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== design/jadm_lane.sv =====
// one channel lane: running sum, scale and clamp, deadband mapping
`default_nettype none
module jadm_lane
   import jadm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic                enable,
   input  wire lane_ctrl_type       ctrl,
   output logic      [AXIS_W-1:0]   axis
);

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   acc;
   logic [SUM_W-1:0]   fin_ff;
   logic               en1_ff;
   logic [V_W-1:0]     v_ff;
   logic               en2_ff;
   logic [PROD_W-1:0]  prod;
   logic [VRAW_W-1:0]  v_raw;
   logic [V_W-1:0]     v_clamp;
   logic [QX_W-1:0]    qx;
   logic [QPROD_W-1:0] qprod;
   logic [AXIS_W-1:0]  q;

   assign acc = sum_ff + (ctrl.add ? SUM_W'(sample) : '0);

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.accept) begin
         sum_in = ctrl.close ? '0 : acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // frame close and scale stages
   always_ff @(posedge clock) begin
      if (ctrl.accept && ctrl.close) begin
         fin_ff <= acc;
         en1_ff <= enable;
      end
      if (ctrl.s2_load) begin
         v_ff   <= v_clamp;
         en2_ff <= en1_ff;
      end
   end

   assign prod  = PROD_W'(fin_ff) * PROD_W'(SCALE_MUL);
   assign v_raw = prod[PROD_W-1:SCALE_SHIFT];

   always_comb begin
      if (v_raw > VRAW_W'(V_MAX)) begin
         v_clamp = V_MAX;
      end else if (v_raw < VRAW_W'(V_MIN)) begin
         v_clamp = V_MIN;
      end else begin
         v_clamp = v_raw[V_W-1:0];
      end
   end

   // deadband map
   always_comb begin
      if (v_ff > V_CENTER) begin
         qx = QX_W'({v_ff - V_CENTER, 4'b0000});
      end else begin
         qx = QX_W'({V_CENTER - v_ff, 4'b0000}) + QX_W'(24);
      end
      qprod = QPROD_W'(qx) * QPROD_W'(RECIP_25);
      q     = qprod[RECIP_SH +: AXIS_W];
      if (!en2_ff) begin
         axis = AXIS_CENTER;
      end else if (v_ff > V_DEAD_LOW && v_ff < V_DEAD_HIGH) begin
         axis = AXIS_CENTER;
      end else if (v_ff > V_CENTER) begin
         axis = AXIS_BASE + q;
      end else begin
         axis = AXIS_CENTER - q;
      end
   end

endmodule
`default_nettype wire

// ===== design/jadm_merge.sv =====
// output register that gathers the lane results into one transfer
`default_nettype none
module jadm_merge
   import jadm_pkg::*;
(
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             load_valid,
   input  wire logic [CHANNELS-1:0][AXIS_W-1:0]  axes,
   output logic                                  load_ready,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [RSP_DATA_W-1:0]            rsp_tdata
);

   logic                  out_v_ff, out_v_in;
   logic [RSP_DATA_W-1:0] data_ff;

   assign load_ready = !out_v_ff || rsp_tready;

   always_comb begin
      out_v_in = out_v_ff;
      if (load_ready) begin
         out_v_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= RSP_DATA_W'(axes);
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = data_ff;

endmodule
`default_nettype wire
